[rtl/hbs_pkg.sv]
// shared types and constants for the histogram bin search block
package hbs_pkg;

    // fixed port widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 32;
    localparam int BIN_W   = 6;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 7;

    // bins_in_use after reset
    localparam logic [CFG_W-1:0] BINS_RESET = 7'd64;

    // operation codes
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_WRITE_EDGE = 2'd0;
    localparam op_t OP_EVENT      = 2'd1;
    localparam op_t OP_READ       = 2'd2;

    // sequencer to search unit
    typedef struct packed {
        logic load;
        logic step;
    } srch_cmd_t;

    // search unit to sequencer
    typedef struct packed {
        logic hit;
        logic empty;
    } srch_stat_t;

endpackage

[rtl/hbs_edge_ram.sv]
// bin edge store: one write port, two registered read ports
module hbs_edge_ram #(
    parameter int DEPTH = 65,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads at low and high edge
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/hbs_count_ram.sv]
// per-bin count store: one write port, one registered read port
module hbs_count_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/hbs_search.sv]
// binary search bounds and the shared edge compare unit
module hbs_search #(
    parameter int EW         = 7,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hbs_pkg::srch_cmd_t     cmd,
    input  logic [EW-1:0]          n_active,
    input  logic [VALUE_BITS-1:0]  energy,
    input  logic [VALUE_BITS-1:0]  low_edge,
    input  logic [VALUE_BITS-1:0]  high_edge,
    output logic [EW-1:0]          mid,
    output hbs_pkg::srch_stat_t    stat
);

    import hbs_pkg::*;

    // lo is the first candidate bin, hi_p one past the last
    logic [EW-1:0] lo_reg;
    logic [EW-1:0] lo_next;
    logic [EW-1:0] hip_reg;
    logic [EW-1:0] hip_next;
    logic [EW:0]   mid_sum;

    // midpoint of the remaining range
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hip_reg} - {{EW{1'b0}}, 1'b1};
    assign mid     = mid_sum[EW:1];

    // strict compare against both edges
    assign stat.hit   = (energy > low_edge) && (energy < high_edge);
    assign stat.empty = !(lo_reg < hip_reg);

    // narrow the range
    always_comb
    begin
        lo_next  = lo_reg;
        hip_next = hip_reg;
        if (cmd.load)
        begin
            lo_next  = '0;
            hip_next = n_active;
        end
        else if (cmd.step)
        begin
            if (low_edge > energy)
            begin
                hip_next = mid;
            end
            else
            begin
                lo_next = mid + {{(EW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hip_reg <= '0;
        end
        else
        begin
            lo_reg  <= lo_next;
            hip_reg <= hip_next;
        end
    end

endmodule

[rtl/histogram_bin_search_top.sv]
// histogram with binary-search binning over a table of bin edges
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | input     | in_valid/in_stall  | operation, index, value
//  out     | output    | out_valid/out_stall| found, bin, count
//  cfg     | input     | cfg_valid/cfg_ready| bins_in_use
//
// An edge write goes straight into the edge store; a read runs count read, count update
// and final state, or just the final state for an index past the last bin; an event runs
// an edge read, then a compare, per search step, up to ceil(log2(bins_in_use+1)) steps,
// plus the count update. The count store is cleared after reset before any input item.
// A finished result waits in the output register while the next item runs;
// the sequencer only holds in its last state if that register is still full.
module histogram_bin_search_top #(
    parameter int MAX_BINS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [hbs_pkg::OP_W-1:0]     operation,
    input  logic [hbs_pkg::INDEX_W-1:0]  index,
    input  logic [hbs_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [hbs_pkg::BIN_W-1:0]    bin,
    output logic [hbs_pkg::COUNT_W-1:0]  count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hbs_pkg::CFG_W-1:0]    bins_in_use
);

    import hbs_pkg::*;

    localparam int EW  = $clog2(MAX_BINS + 1);
    localparam int BW  = $clog2(MAX_BINS);
    localparam int NW0 = (EW > INDEX_W) ? EW : INDEX_W;
    localparam int NW  = (NW0 > CFG_W) ? NW0 : CFG_W;
    localparam logic [NW-1:0] MAX_N    = NW'(MAX_BINS);
    localparam logic [BW-1:0] CLR_LAST = BW'(MAX_BINS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_CNT_RD,
        S_CNT_UPD,
        S_DONE
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    op_t                    op_reg;
    op_t                    op_next;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [VALUE_BITS-1:0]  val_next;
    logic [BW-1:0]          addr_reg;
    logic [BW-1:0]          addr_next;
    logic [BW-1:0]          clr_reg;
    logic [BW-1:0]          clr_next;
    logic                   res_found_reg;
    logic                   res_found_next;
    logic [BIN_W-1:0]       res_bin_reg;
    logic [BIN_W-1:0]       res_bin_next;
    logic [COUNT_W-1:0]     res_count_reg;
    logic [COUNT_W-1:0]     res_count_next;
    logic [CFG_W-1:0]       bins_reg;
    logic [CFG_W-1:0]       bins_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic                   out_found_next;
    logic [BIN_W-1:0]       out_bin_reg;
    logic [BIN_W-1:0]       out_bin_next;
    logic [COUNT_W-1:0]     out_count_reg;
    logic [COUNT_W-1:0]     out_count_next;

    logic [NW-1:0]          idx_ext;
    logic [NW-1:0]          bins_ext;
    logic [EW-1:0]          n_active;
    logic [VALUE_BITS-1:0]  val_in;

    logic                   e_we;
    logic [VALUE_BITS-1:0]  low_edge;
    logic [VALUE_BITS-1:0]  high_edge;
    logic [EW-1:0]          mid_p1;

    logic                   c_we;
    logic [BW-1:0]          c_waddr;
    logic [COUNT_BITS-1:0]  c_wdata;
    logic [COUNT_BITS-1:0]  c_rdata;
    logic [COUNT_BITS-1:0]  cnt_inc;

    srch_cmd_t              srch_cmd;
    srch_stat_t             srch_stat;
    logic [EW-1:0]          srch_mid;

    // input field widening and masking
    assign idx_ext  = NW'(index);
    assign val_in   = VALUE_BITS'(value);
    assign bins_ext = NW'(bins_reg);

    // bins searched, clamped to one..MAX_BINS
    always_comb
    begin
        if (bins_ext == '0)
        begin
            n_active = {{(EW-1){1'b0}}, 1'b1};
        end
        else if (bins_ext > MAX_N)
        begin
            n_active = EW'(MAX_BINS);
        end
        else
        begin
            n_active = EW'(bins_ext);
        end
    end

    // handshake outputs
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign bin       = out_bin_reg;
    assign count     = out_count_reg;

    // edge store, written straight from an accepted edge item
    assign e_we   = in_valid && (state_reg == S_IDLE) && (operation == OP_WRITE_EDGE)
                    && (idx_ext <= MAX_N);
    assign mid_p1 = srch_mid + {{(EW-1){1'b0}}, 1'b1};

    hbs_edge_ram #(
        .DEPTH (MAX_BINS + 1),
        .WIDTH (VALUE_BITS),
        .AW    (EW)
    ) u_edge_ram (
        .clk     (clk),
        .we      (e_we),
        .waddr   (idx_ext[EW-1:0]),
        .wdata   (val_in),
        .raddr_a (srch_mid),
        .raddr_b (mid_p1),
        .rdata_a (low_edge),
        .rdata_b (high_edge)
    );

    hbs_search #(
        .EW         (EW),
        .VALUE_BITS (VALUE_BITS)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (srch_cmd),
        .n_active  (n_active),
        .energy    (val_reg),
        .low_edge  (low_edge),
        .high_edge (high_edge),
        .mid       (srch_mid),
        .stat      (srch_stat)
    );

    // count store: clear pass or saturating update
    assign cnt_inc = (c_rdata == '1) ? c_rdata : c_rdata + COUNT_BITS'(1);
    assign c_waddr = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign c_wdata = (state_reg == S_CLEAR) ? '0 : cnt_inc;
    assign c_we    = (state_reg == S_CLEAR)
                     || ((state_reg == S_CNT_UPD) && (op_reg == OP_EVENT));

    hbs_count_ram #(
        .DEPTH (MAX_BINS),
        .WIDTH (COUNT_BITS),
        .AW    (BW)
    ) u_count_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (addr_reg),
        .rdata (c_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        res_found_next = res_found_reg;
        res_bin_next   = res_bin_reg;
        res_count_next = res_count_reg;
        bins_next      = bins_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_found_next = out_found_reg;
        out_bin_next   = out_bin_reg;
        out_count_next = out_count_reg;
        srch_cmd       = '0;

        // register write
        if (cfg_valid)
        begin
            bins_next = bins_in_use;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + BW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    case (operation)
                        OP_EVENT:
                        begin
                            val_next      = val_in;
                            srch_cmd.load = 1'b1;
                            state_next    = S_ADDR;
                        end
                        OP_READ:
                        begin
                            res_found_next = 1'b0;
                            res_bin_next   = BIN_W'(index);
                            if (idx_ext < MAX_N)
                            begin
                                addr_next  = idx_ext[BW-1:0];
                                state_next = S_CNT_RD;
                            end
                            else
                            begin
                                res_count_next = '0;
                                state_next     = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADDR:
            begin
                // range exhausted: miss
                if (srch_stat.empty)
                begin
                    res_found_next = 1'b0;
                    res_bin_next   = '0;
                    res_count_next = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (srch_stat.hit)
                begin
                    addr_next    = BW'(srch_mid);
                    res_bin_next = BIN_W'(srch_mid);
                    state_next   = S_CNT_RD;
                end
                else
                begin
                    srch_cmd.step = 1'b1;
                    state_next    = S_ADDR;
                end
            end
            S_CNT_RD:
            begin
                state_next = S_CNT_UPD;
            end
            S_CNT_UPD:
            begin
                if (op_reg == OP_EVENT)
                begin
                    res_found_next = 1'b1;
                    res_count_next = COUNT_W'(cnt_inc);
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_count_next = COUNT_W'(c_rdata);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_bin_next   = res_bin_reg;
                    out_count_next = res_count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            bins_reg      <= BINS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bins_reg      <= bins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        addr_reg      <= addr_next;
        res_found_reg <= res_found_next;
        res_bin_reg   <= res_bin_next;
        res_count_reg <= res_count_next;
        out_found_reg <= out_found_next;
        out_bin_reg   <= out_bin_next;
        out_count_reg <= out_count_next;
    end

    // search never probes a bin outside the active range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (srch_mid < n_active))
        else $error("search midpoint outside active bins");

    // a counted event never wraps its bin count
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CNT_UPD) && (op_reg == OP_EVENT)) |-> (cnt_inc != '0))
        else $error("bin count wrapped");

    // a new result enters the output register only from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside final state");

    // clear pass hands over to idle right after the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CLEAR) && (clr_reg == CLR_LAST)) |=> (state_reg == S_IDLE))
        else $error("clear pass did not finish");

endmodule
